FILE: rtl/lattice_gas_site_update_defines.svh
// Assertion macros shared by the lattice gas site update RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LATTICE_GAS_SITE_UPDATE_DEFINES_SVH
`define LATTICE_GAS_SITE_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGSU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lgsu_pkg.sv
// Types, codes and the neighbor offset table for the lattice gas site update.
// No dependencies.
package lgsu_pkg;

    localparam int SP_W    = 5;
    localparam int COORD_W = 5;
    localparam int RND_W   = 16;
    localparam int THR_W   = 17;
    localparam int SUM_W   = 12;
    localparam int STEP_W  = 3;

    // steps: 0 is the site itself, 1..6 the triangular neighbors
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_INSERT  = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_REPLACE = 2'd3;

    localparam logic REG_INSERT_THR = 1'b0;
    localparam logic REG_REMOVE_THR = 1'b1;

    // two's complement row/col offsets
    typedef struct packed {
        logic [1:0] dr;
        logic [1:0] dc;
    } nbr_off_t;

    typedef struct packed {
        logic            fire;
        logic [1:0]      kind;
        logic            conflict;
        logic [SP_W-1:0] old_sp;
        logic [SP_W-1:0] new_sp;
        logic            odd;
    } res_t;

    function automatic nbr_off_t nbr_off(input logic [STEP_W-1:0] step);
        nbr_off_t o;
        case (step)
            3'd0:    o = '{dr: 2'b00, dc: 2'b00};
            3'd1:    o = '{dr: 2'b11, dc: 2'b00};
            3'd2:    o = '{dr: 2'b01, dc: 2'b00};
            3'd3:    o = '{dr: 2'b00, dc: 2'b11};
            3'd4:    o = '{dr: 2'b00, dc: 2'b01};
            3'd5:    o = '{dr: 2'b11, dc: 2'b01};
            3'd6:    o = '{dr: 2'b01, dc: 2'b11};
            default: o = '{dr: 2'b00, dc: 2'b00};
        endcase
        return o;
    endfunction

endpackage

FILE: rtl/lgsu_store.sv
// Single-port site store: one read or one write per cycle, registered read data.
// Depends on lgsu_pkg.
module lgsu_store #(
    parameter int DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                st_en,
    input  logic                                st_we,
    input  logic [$clog2(DEPTH)-1:0]            st_addr,
    input  logic [lgsu_pkg::SP_W-1:0]           st_wdata,
    output logic [lgsu_pkg::SP_W-1:0]           st_rdata
);
    import lgsu_pkg::*;

    logic [SP_W-1:0] mem_reg [DEPTH];
    logic [SP_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (st_en) begin
            if (st_we) begin
                mem_reg[st_addr] <= st_wdata;
            end else begin
                rdata_reg <= mem_reg[st_addr];
            end
        end
    end

    assign st_rdata = rdata_reg;

endmodule

FILE: rtl/lgsu_seq.sv
// Sequencer: store clearing pass, seven-read neighbor scan through one shared
// address generator and clash compare, move rule. Depends on lgsu_pkg, lgsu_store.
`include "lattice_gas_site_update_defines.svh"

module lgsu_seq #(
    parameter int SIDE    = 32,
    parameter int SPECIES = 29
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lgsu_pkg::COORD_W-1:0]  in_row,
    input  logic [lgsu_pkg::COORD_W-1:0]  in_col,
    input  logic [lgsu_pkg::SP_W-1:0]     in_sp,
    input  logic [lgsu_pkg::RND_W-1:0]    in_rnd,
    input  logic [lgsu_pkg::THR_W-1:0]    ins_thr,
    input  logic [lgsu_pkg::THR_W-1:0]    rem_thr,
    input  logic                          out_free,
    output lgsu_pkg::res_t                res
);
    import lgsu_pkg::*;

    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = ($clog2(SIDE + 1) > 6) ? $clog2(SIDE + 1) : 6;
    localparam int SPC_W = ($clog2(SPECIES + 1) > SP_W) ? $clog2(SPECIES + 1) : SP_W;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               pend_site_reg, pend_site_next;
    logic               pend_nbr_reg, pend_nbr_next;

    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic               site_ok_reg, site_ok_next;
    logic               cf_reg, cf_next;
    logic [SP_W-1:0]    old_reg, old_next;
    logic [AW-1:0]      site_addr_reg, site_addr_next;

    logic               st_en, st_we;
    logic [AW-1:0]      st_addr;
    logic [SP_W-1:0]    st_wdata, st_rdata;

    nbr_off_t           off;
    logic [CW-1:0]      nr, nc;
    logic               in_rng;
    logic [AW-1:0]      lin;
    logic               clash_now, cf_acc;
    logic               in_fire;
    logic               sp_ok, ins_ok, rem_ok;
    logic [1:0]         kind;
    logic [SP_W-1:0]    new_sp;

    lgsu_store #(.DEPTH(DEPTH)) u_store (
        .aclk     (aclk),
        .st_en    (st_en),
        .st_we    (st_we),
        .st_addr  (st_addr),
        .st_wdata (st_wdata),
        .st_rdata (st_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid & in_ready;

    // shared address generator: (row+dr)*SIDE + (col+dc), range check by wrap
    always_comb begin
        off    = nbr_off(step_reg);
        nr     = CW'(row_reg) + {{(CW-2){off.dr[1]}}, off.dr};
        nc     = CW'(col_reg) + {{(CW-2){off.dc[1]}}, off.dc};
        in_rng = (nr < CW'(SIDE)) && (nc < CW'(SIDE));
        lin    = AW'(nr) * AW'(SIDE) + AW'(nc);
    end

    // shared clash compare on the word returned by the store
    assign clash_now = (st_rdata != '0) && (st_rdata != sp_reg);
    assign cf_acc    = cf_reg | (pend_nbr_reg & clash_now);

    // move rule
    always_comb begin
        sp_ok  = SPC_W'(sp_reg) <= SPC_W'(SPECIES);
        ins_ok = {1'b0, rnd_reg} < ins_thr;
        rem_ok = {1'b0, rnd_reg} < rem_thr;
        kind   = KIND_NONE;
        new_sp = old_reg;
        if (sp_ok) begin
            if (old_reg == '0) begin
                if ((sp_reg != '0) && !cf_acc && ins_ok) begin
                    kind   = KIND_INSERT;
                    new_sp = sp_reg;
                end
            end else if (sp_reg == '0) begin
                if (rem_ok) begin
                    kind   = KIND_REMOVE;
                    new_sp = '0;
                end
            end else if (!cf_acc && (sp_reg != old_reg)) begin
                kind   = KIND_REPLACE;
                new_sp = sp_reg;
            end
        end
        res.fire     = (state_reg == ST_DECIDE) && out_free;
        res.kind     = site_ok_reg ? kind : KIND_NONE;
        res.conflict = site_ok_reg & cf_acc;
        res.old_sp   = site_ok_reg ? old_reg : '0;
        res.new_sp   = site_ok_reg ? new_sp : '0;
        res.odd      = row_reg[0] ^ col_reg[0];
    end

    // store port
    always_comb begin
        st_en    = 1'b0;
        st_we    = 1'b0;
        st_addr  = '0;
        st_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                st_en   = 1'b1;
                st_we   = 1'b1;
                st_addr = clr_reg;
            end
            ST_READ: begin
                st_en   = in_rng;
                st_addr = in_rng ? lin : '0;
            end
            ST_DECIDE: begin
                st_en    = out_free & site_ok_reg;
                st_we    = 1'b1;
                st_addr  = site_addr_reg;
                st_wdata = new_sp;
            end
            default: begin
                st_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        clr_next       = clr_reg;
        pend_site_next = 1'b0;
        pend_nbr_next  = 1'b0;
        row_next       = row_reg;
        col_next       = col_reg;
        sp_next        = sp_reg;
        rnd_next       = rnd_reg;
        site_ok_next   = site_ok_reg;
        cf_next        = cf_acc;
        old_next       = pend_site_reg ? st_rdata : old_reg;
        site_addr_next = site_addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    row_next     = in_row;
                    col_next     = in_col;
                    sp_next      = in_sp;
                    rnd_next     = in_rnd;
                    site_ok_next = (CW'(in_row) < CW'(SIDE)) && (CW'(in_col) < CW'(SIDE));
                    cf_next      = 1'b0;
                    old_next     = '0;
                    step_next    = '0;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                pend_site_next = in_rng && (step_reg == '0);
                pend_nbr_next  = in_rng && (step_reg != '0);
                if (step_reg == '0) begin
                    site_addr_next = lin;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            pend_site_reg <= 1'b0;
            pend_nbr_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            pend_site_reg <= pend_site_next;
            pend_nbr_reg  <= pend_nbr_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        sp_reg        <= sp_next;
        rnd_reg       <= rnd_next;
        site_ok_reg   <= site_ok_next;
        cf_reg        <= cf_next;
        old_reg       <= old_next;
        site_addr_reg <= site_addr_next;
    end

    `LGSU_ASSERT_NXT(a_accept_starts_scan, aclk, aresetn, in_fire, (state_reg == ST_READ) && (step_reg == '0), "accepted word did not start the scan at the site")
    `LGSU_ASSERT_IMP(a_write_phase, aclk, aresetn, st_en && st_we, (state_reg == ST_CLEAR) || (state_reg == ST_DECIDE), "store written outside clear or decide")
    `LGSU_ASSERT_IMP(a_fire_needs_room, aclk, aresetn, res.fire, out_free, "result issued while output register full")
    `LGSU_ASSERT_IMP(a_old_settled, aclk, aresetn, state_reg == ST_DECIDE, !pend_site_reg, "site species still in flight at decide")

endmodule

FILE: rtl/lattice_gas_site_update.sv
// Top level of the lattice gas site update: APB register file, staggered
// order sum, output register. Depends on lgsu_pkg, lgsu_seq.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------
//  s_        | in        | s_tvalid / s_tready       | s_tdata: row, col, species, rnd
//  m_        | out       | m_tvalid / m_tready       | m_tdata: kind, conflict, old,
//            |           |                           |          new, order_sum
//  apb       | in        | psel / penable / pready   | paddr, pwdata, prdata
//
// Each word passes through an accept state, seven reads of the single-port
// site store (the site and its six triangular neighbors) and a decide state
// that writes the site back and loads the output register.
// The decide cycle waits while the output register holds an untaken word.
// After reset the store is cleared one entry a cycle, all SIDE*SIDE entries
// (1024 by default), during which s_tready stays low; APB writes still land.
// Reset is synchronous, active low; thresholds come up at 65536 and 13107.
module lattice_gas_site_update #(
    parameter int SIDE    = 32,
    parameter int SPECIES = 29
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [4:0] site_row, [9:5] site_col,
                                   // [14:10] proposed_species, [30:15] random_word
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] move_kind, [2] neighbor_conflict,
                                   // [7:3] old_species, [12:8] new_species,
                                   // [24:13] order_sum
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lgsu_pkg::*;

    localparam logic [SUM_W-1:0] TOTAL_RST = (SIDE % 2 == 0) ? '0 : '1;
    localparam logic [THR_W-1:0] INS_RST   = 17'd65536;
    localparam logic [THR_W-1:0] REM_RST   = 17'd13107;

    logic [THR_W-1:0] ins_thr_reg, ins_thr_next;
    logic [THR_W-1:0] rem_thr_reg, rem_thr_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic             m_valid_reg, m_valid_next;
    logic [24:0]      m_data_reg, m_data_next;
    logic             cfg_wr;
    logic             reg_idx;
    logic             out_free;
    res_t             res;

    lgsu_seq #(
        .SIDE    (SIDE),
        .SPECIES (SPECIES)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_row   (s_tdata[4:0]),
        .in_col   (s_tdata[9:5]),
        .in_sp    (s_tdata[14:10]),
        .in_rnd   (s_tdata[30:15]),
        .ins_thr  (ins_thr_reg),
        .rem_thr  (rem_thr_reg),
        .out_free (out_free),
        .res      (res)
    );

    // register port: byte address 4*i, low address bits ignored
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        ins_thr_next = ins_thr_reg;
        rem_thr_next = rem_thr_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_INSERT_THR: ins_thr_next = pwdata[THR_W-1:0];
                REG_REMOVE_THR: rem_thr_next = pwdata[THR_W-1:0];
                default:        ins_thr_next = ins_thr_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INSERT_THR: prdata = {{(32-THR_W){1'b0}}, ins_thr_reg};
            REG_REMOVE_THR: prdata = {{(32-THR_W){1'b0}}, rem_thr_reg};
            default:        prdata = '0;
        endcase
    end

    // staggered sum: insert adds 2*(-1)^(r+c), remove takes it away
    always_comb begin
        total_next = total_reg;
        if (res.fire) begin
            case (res.kind)
                KIND_INSERT: total_next = res.odd ? total_reg - SUM_W'(2)
                                                  : total_reg + SUM_W'(2);
                KIND_REMOVE: total_next = res.odd ? total_reg + SUM_W'(2)
                                                  : total_reg - SUM_W'(2);
                default:     total_next = total_reg;
            endcase
        end
    end

    // output register: free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res.fire) begin
            m_valid_next = 1'b1;
            m_data_next  = {total_next, res.new_sp, res.old_sp, res.conflict, res.kind};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_thr_reg <= INS_RST;
            rem_thr_reg <= REM_RST;
            total_reg   <= TOTAL_RST;
            m_valid_reg <= 1'b0;
        end else begin
            ins_thr_reg <= ins_thr_next;
            rem_thr_reg <= rem_thr_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

endmodule
